>>> sv/clt_pkg.sv
// Shared types and constants for the character LCD text terminal.
`timescale 1ns / 1ps

package clt_pkg;

	localparam int CLT_MAX_COLUMNS = 20;
	localparam int SHD_AW = 7;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_TILDE_GLYPH = 8'hF3;
	localparam logic [7:0] CH_SKIP = 8'h8E;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CTRL_LO = 8'h10;
	localparam logic [7:0] CH_CTRL_HI = 8'h1F;

	localparam logic [6:0] ROW1_BASE = 7'd64;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_SETADDR = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic REQ_PUT = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	localparam logic REG_FOUR_ROWS = 1'b0;
	localparam logic REG_COLUMNS = 1'b1;

	typedef struct packed {
		logic       req_type;
		logic [7:0] char_code;
	} in_word_t;

	typedef struct packed {
		logic [1:0] op_kind;
		logic [6:0] address;
		logic [7:0] char_out;
		logic       last;
	} out_word_t;

	typedef struct packed {
		logic              we;
		logic [SHD_AW-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [SHD_AW-1:0] raddr;
		logic              inv;
		logic [SHD_AW-1:0] iaddr;
	} shd_req_t;

endpackage

>>> sv/clt_shadow.sv
// Shadow screen store: one write port, one registered read port, per-entry valid bits.
`timescale 1ns / 1ps

module clt_shadow import clt_pkg::*; #(
	parameter int MAX_COLUMNS = CLT_MAX_COLUMNS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  shd_req_t   req,
	output logic [7:0] rdata
);

	localparam int DEPTH = 4 * MAX_COLUMNS;
	localparam int AW = $clog2(DEPTH);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [7:0]       data_s1;
	logic             hit_s1;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[AW-1:0]] <= req.wdata;
		end
		if (req.re) begin
			data_s1 <= mem[req.raddr[AW-1:0]];
		end
	end

	// cleared entries read back as space
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_s1 <= 1'b0;
		end else begin
			if (req.inv) begin
				vld_q[req.iaddr[AW-1:0]] <= 1'b0;
			end
			if (req.we) begin
				vld_q[req.waddr[AW-1:0]] <= 1'b1;
			end
			if (req.re) begin
				hit_s1 <= vld_q[req.raddr[AW-1:0]];
			end
		end
	end

	assign rdata = hit_s1 ? data_s1 : CH_SPACE;

endmodule

>>> sv/char_lcd_text_terminal.sv
// Top level of the character LCD text terminal: sequencer, cursor, config, output register.
//
//  channel   | signals                                   | word
//  ----------+-------------------------------------------+-----------------------------
//  input     | in_valid, in_stall, in_data               | req_type, char_code
//  output    | out_valid, out_stall, out_data            | op_kind, address, char_out, last
//  config    | psel, penable, pwrite, paddr, pwdata, ... | four_rows @0, columns @4
//
// Ignored characters stay in IDLE; a clear runs HOME, a plain write CHAR then EOR, a newline EOR then ADDR.
// A scroll runs CLR, RD and EMIT with one shadow read per word, through the single read port
// of the shadow store. No word is taken while busy.
// Reset homes the cursor and marks the whole shadow as spaces at once.
// Output stalls hold the sequencer; the output register frees one word of slack.
`timescale 1ns / 1ps

module char_lcd_text_terminal import clt_pkg::*; #(
	parameter int MAX_COLUMNS = CLT_MAX_COLUMNS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_data
);

	localparam int BANK = 2 * MAX_COLUMNS;
	localparam logic [6:0] BANK7 = 7'(BANK);
	localparam logic [4:0] MAXC5 = 5'(MAX_COLUMNS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CHAR = 3'd1;
	localparam logic [2:0] ST_EOR = 3'd2;
	localparam logic [2:0] ST_CLR = 3'd3;
	localparam logic [2:0] ST_RD = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;
	localparam logic [2:0] ST_ADDR = 3'd6;
	localparam logic [2:0] ST_HOME = 3'd7;

	logic [2:0] state_q;
	logic       four_rows_q;
	logic [4:0] columns_q;
	logic [6:0] cursor_q, addr_q;
	logic [7:0] ch_q;
	logic       nl_q, four_q, mode4_q;
	logic [4:0] c_q, i_q;
	logic       sub_q, phb_q;
	logic [6:0] waddr_s2, oaddr_s2, iaddr_s2;
	logic       inv_s2, last_s2;
	logic       out_valid_q;
	out_word_t  out_q;

	logic       in_acc, slot_free, push, issue;
	out_word_t  pw;
	shd_req_t   shd;
	logic [7:0] rdata;

	logic [4:0] c_eff;
	logic [6:0] ce7, ce2, cep64, ce2p64, nl_tgt;
	logic [7:0] ch_map;
	logic       ch_ign;
	logic [6:0] c7, c2_7, cp64, c2p64, i7;
	logic       scroll_pend;
	logic [6:0] cw_idx;
	logic       cw_ok;
	logic [6:0] st_rd, st_wr, st_oa;
	logic       st_inv, st_last, last_idx;
	logic [4:0] nxt_i;
	logic       nxt_sub, nxt_phb;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_COLUMNS) ? {27'd0, columns_q} : {31'd0, four_rows_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_rows_q <= 1'b0;
			columns_q <= 5'd16;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_FOUR_ROWS: four_rows_q <= pwdata[0];
				REG_COLUMNS: columns_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	// input decode
	always_comb begin
		if (columns_q == 5'd0) begin
			c_eff = 5'd1;
		end else if (columns_q > MAXC5) begin
			c_eff = MAXC5;
		end else begin
			c_eff = columns_q;
		end
		ce7 = {2'd0, c_eff};
		ce2 = {1'b0, c_eff, 1'b0};
		cep64 = ce7 + ROW1_BASE;
		ce2p64 = ce2 + ROW1_BASE;
		if (cursor_q < ce7) begin
			nl_tgt = ce7;
		end else if (cursor_q < ce2) begin
			nl_tgt = ce2;
		end else if (cursor_q < ROW1_BASE) begin
			nl_tgt = '0;
		end else if (cursor_q < cep64) begin
			nl_tgt = cep64;
		end else if (cursor_q < ce2p64) begin
			nl_tgt = ce2p64;
		end else begin
			nl_tgt = '0;
		end
		ch_map = (in_data.char_code == CH_TILDE) ? CH_TILDE_GLYPH : in_data.char_code;
		ch_ign = ch_map inside {CH_SKIP, CH_CR, [CH_CTRL_LO:CH_CTRL_HI]};
	end

	// geometry of the latched layout
	always_comb begin
		c7 = {2'd0, c_q};
		c2_7 = {1'b0, c_q, 1'b0};
		cp64 = c7 + ROW1_BASE;
		c2p64 = c2_7 + ROW1_BASE;
		i7 = {2'd0, i_q};
		scroll_pend = (cursor_q == c2p64) || ((cursor_q == cp64) && !four_q);
		cw_ok = {1'b0, addr_q[5:0]} < BANK7;
		cw_idx = addr_q[6] ? BANK7 + {1'b0, addr_q[5:0]} : {1'b0, addr_q[5:0]};
	end

	// scroll step: source, destination, display address
	always_comb begin
		last_idx = (i_q == c_q - 5'd1);
		st_inv = 1'b0;
		st_last = 1'b0;
		if (!mode4_q || phb_q) begin
			st_rd = BANK7 + (mode4_q ? c7 : 7'd0) + i7;
			st_wr = (mode4_q ? c7 : 7'd0) + i7;
			st_oa = st_wr;
			st_inv = 1'b1;
			st_last = last_idx;
		end else if (!sub_q) begin
			st_rd = BANK7 + i7;
			st_wr = i7;
			st_oa = i7;
		end else begin
			st_rd = c7 + i7;
			st_wr = BANK7 + i7;
			st_oa = ROW1_BASE + i7;
		end
		nxt_i = i_q;
		nxt_sub = sub_q;
		nxt_phb = phb_q;
		if (!mode4_q || phb_q) begin
			nxt_i = i_q + 5'd1;
		end else if (!sub_q) begin
			nxt_sub = 1'b1;
		end else begin
			nxt_sub = 1'b0;
			if (last_idx) begin
				nxt_i = 5'd0;
				nxt_phb = 1'b1;
			end else begin
				nxt_i = i_q + 5'd1;
			end
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	// word to push and shadow access
	always_comb begin
		pw = '0;
		push = 1'b0;
		case (state_q)
			ST_HOME: begin
				pw.op_kind = OP_CLEAR;
				pw.last = 1'b1;
				push = slot_free;
			end
			ST_CLR: begin
				pw.op_kind = OP_CLEAR;
				push = slot_free;
			end
			ST_ADDR: begin
				pw.op_kind = OP_SETADDR;
				pw.address = cursor_q;
				pw.last = 1'b1;
				push = slot_free;
			end
			ST_CHAR: begin
				pw.op_kind = OP_WRITE;
				pw.address = addr_q;
				pw.char_out = ch_q;
				pw.last = !scroll_pend;
				push = slot_free;
			end
			ST_EMIT: begin
				pw.op_kind = OP_WRITE;
				pw.address = oaddr_s2;
				pw.char_out = rdata;
				pw.last = last_s2 && !nl_q;
				push = slot_free;
			end
			default: ;
		endcase
		issue = (state_q == ST_RD) || ((state_q == ST_EMIT) && push && !last_s2);
		shd = '0;
		shd.re = issue;
		shd.raddr = st_rd;
		if (state_q == ST_CHAR) begin
			shd.we = push && cw_ok;
			shd.waddr = cw_idx;
			shd.wdata = ch_q;
		end else begin
			shd.we = (state_q == ST_EMIT) && push;
			shd.waddr = waddr_s2;
			shd.wdata = rdata;
		end
		shd.inv = (state_q == ST_EMIT) && push && inv_s2;
		shd.iaddr = iaddr_s2;
	end

	clt_shadow #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_shadow (
		.clk(clk),
		.arst_n(arst_n),
		.req(shd),
		.rdata(rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cursor_q <= '0;
			nl_q <= 1'b0;
			mode4_q <= 1'b0;
			four_q <= 1'b0;
			c_q <= 5'd1;
			i_q <= '0;
			sub_q <= 1'b0;
			phb_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						c_q <= c_eff;
						four_q <= four_rows_q;
						if (in_data.req_type == REQ_CLEAR) begin
							cursor_q <= '0;
							state_q <= ST_HOME;
						end else if (ch_map == CH_LF) begin
							cursor_q <= nl_tgt;
							nl_q <= 1'b1;
							state_q <= ST_EOR;
						end else if (!ch_ign) begin
							cursor_q <= cursor_q + 7'd1;
							nl_q <= 1'b0;
							state_q <= ST_CHAR;
						end
					end
				end
				ST_CHAR: begin
					if (push) begin
						state_q <= ST_EOR;
					end
				end
				ST_EOR: begin
					i_q <= '0;
					sub_q <= 1'b0;
					phb_q <= 1'b0;
					state_q <= nl_q ? ST_ADDR : ST_IDLE;
					if (cursor_q == c2p64) begin
						cursor_q <= cp64;
						mode4_q <= 1'b1;
						state_q <= ST_CLR;
					end else if (cursor_q == c2_7) begin
						cursor_q <= cp64;
					end else if (cursor_q == cp64) begin
						if (four_q) begin
							cursor_q <= c7;
						end else begin
							cursor_q <= ROW1_BASE;
							mode4_q <= 1'b0;
							state_q <= ST_CLR;
						end
					end else if (cursor_q == c7) begin
						cursor_q <= ROW1_BASE;
					end
				end
				ST_CLR: begin
					if (push) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (push && last_s2) begin
						state_q <= nl_q ? ST_ADDR : ST_IDLE;
					end
				end
				ST_ADDR, ST_HOME: begin
					if (push) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (issue && !st_last) begin
				i_q <= nxt_i;
				sub_q <= nxt_sub;
				phb_q <= nxt_phb;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			addr_q <= cursor_q;
			ch_q <= ch_map;
		end
		if (issue) begin
			waddr_s2 <= st_wr;
			oaddr_s2 <= st_oa;
			iaddr_s2 <= st_rd;
			inv_s2 <= st_inv;
			last_s2 <= st_last;
		end
		if (push) begin
			out_q <= pw;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		shd.we && shd.re |-> shd.waddr != shd.raddr)
		else $error("shadow read and write hit the same entry");

	a_scroll_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_EMIT) |-> i_q < c_q)
		else $error("scroll index beyond row length");

	a_clear_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.op_kind == OP_CLEAR |-> out_q.address == 7'd0 && out_q.char_out == 8'd0)
		else $error("clear word carries address or character");

	a_no_unused_op: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.op_kind != OP_UNUSED)
		else $error("undefined operation kind");

	a_home: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_data.req_type == REQ_CLEAR |=> state_q == ST_HOME && cursor_q == 7'd0)
		else $error("clear request did not home cursor");

endmodule

>>> sim/char_lcd_text_terminal_tb.sv
// Self-checking testbench for char_lcd_text_terminal: display-op prediction, random stalls, layouts.
`timescale 1ns / 1ps

module char_lcd_text_terminal_tb;
	import clt_pkg::*;

	localparam int SHADOW_BANK = 2 * CLT_MAX_COLUMNS;
	localparam int SHADOW_SIZE = 4 * CLT_MAX_COLUMNS;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 100;

	typedef struct {
		in_word_t word;
		bit       drain;
	} feed_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_word_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_word_t   out_data;

	feed_t     text_feed_q[$];
	out_word_t display_ops_q[$];
	out_word_t step_ops[$];

	logic [7:0] shadow_text [0:SHADOW_SIZE-1];
	logic [6:0] cursor_addr;
	logic       lay_four_rows;
	logic [4:0] lay_columns;

	bit     idling = 1'b1;
	int     words_queued = 0;
	int     words_taken = 0;
	int     ops_checked = 0;
	int     scroll_count = 0;
	int     layout_count = 0;
	int     fail_count = 0;
	int     send_gap = 0;
	int     stall_left = 0;
	longint cycle_count = 0;

	char_lcd_text_terminal DUT (.*);

	always #6 clk = ~clk;

	function automatic void report_failure(string msg);
		fail_count++;
		if (fail_count <= 10) $display("ERROR: %s", msg);
	endfunction

	function automatic void emit_op(logic [1:0] kind, int addr, int ch);
		out_word_t w;
		w.op_kind = kind;
		w.address = addr[6:0];
		w.char_out = ch[7:0];
		w.last = 1'b0;
		step_ops.push_back(w);
	endfunction

	// cursor hit a row boundary: move on, scroll and redraw if past the last row
	function automatic void row_end(int c);
		int cur;
		cur = cursor_addr;
		if (cur == 2 * c + 64) begin
			cursor_addr = 7'(c + 64);
			scroll_count++;
			emit_op(OP_CLEAR, 0, 0);
			for (int i = 0; i < c; i++) begin
				shadow_text[i] = shadow_text[SHADOW_BANK + i];
				shadow_text[SHADOW_BANK + i] = shadow_text[c + i];
				shadow_text[c + i] = shadow_text[SHADOW_BANK + c + i];
			end
			for (int i = 0; i < c; i++) begin
				emit_op(OP_WRITE, i, shadow_text[i]);
				emit_op(OP_WRITE, i + 64, shadow_text[SHADOW_BANK + i]);
			end
			for (int i = 0; i < c; i++) begin
				emit_op(OP_WRITE, i + c, shadow_text[c + i]);
				shadow_text[SHADOW_BANK + c + i] = CH_SPACE;
			end
		end else if (cur == 2 * c) begin
			cursor_addr = 7'(64 + c);
		end else if (cur == c + 64) begin
			if (lay_four_rows) begin
				cursor_addr = 7'(c);
			end else begin
				cursor_addr = ROW1_BASE;
				scroll_count++;
				emit_op(OP_CLEAR, 0, 0);
				for (int i = 0; i < c; i++) begin
					shadow_text[i] = shadow_text[SHADOW_BANK + i];
					emit_op(OP_WRITE, i, shadow_text[i]);
					shadow_text[SHADOW_BANK + i] = CH_SPACE;
				end
			end
		end else if (cur == c) begin
			cursor_addr = ROW1_BASE;
		end
	endfunction

	function automatic void predict_display_ops(in_word_t w);
		int c, ch, cur, off, bank;
		out_word_t tail;
		c = lay_columns;
		ch = w.char_code;
		if (c < 1) c = 1;
		if (c > CLT_MAX_COLUMNS) c = CLT_MAX_COLUMNS;
		step_ops.delete();
		if (w.req_type == REQ_CLEAR) begin
			cursor_addr = '0;
			emit_op(OP_CLEAR, 0, 0);
		end else begin
			if (ch == CH_TILDE) ch = CH_TILDE_GLYPH;
			if (ch == CH_SKIP || ch == CH_CR || (ch >= CH_CTRL_LO && ch <= CH_CTRL_HI)) return;
			cur = cursor_addr;
			if (ch == CH_LF) begin
				if (cur < c) cur = c;
				else if (cur < 2 * c) cur = 2 * c;
				else if (cur < 64) cur = 0;
				else if (cur < 64 + c) cur = 64 + c;
				else if (cur < 2 * c + 64) cur = 2 * c + 64;
				else cur = 0;
				cursor_addr = 7'(cur);
				row_end(c);
				emit_op(OP_SETADDR, cursor_addr, 0);
			end else begin
				emit_op(OP_WRITE, cur, ch);
				bank = (cur >= 64) ? 1 : 0;
				off = cur - 64 * bank;
				// past the shadow the display still gets the write
				if (off < SHADOW_BANK) shadow_text[bank * SHADOW_BANK + off] = 8'(ch);
				cursor_addr = 7'(cur + 1);
				row_end(c);
			end
		end
		tail = step_ops.pop_back();
		tail.last = 1'b1;
		step_ops.push_back(tail);
		foreach (step_ops[i]) display_ops_q.push_back(step_ops[i]);
	endfunction

	function automatic void queue_word(in_word_t w, bit drain);
		feed_t f;
		f.word = w;
		f.drain = drain;
		text_feed_q.push_back(f);
		words_queued++;
	endfunction

	function automatic in_word_t random_text_word(bit plain_only, output bit noise);
		int pick;
		logic [7:0] ch;
		pick = plain_only ? 99 : $urandom_range(0, 99);
		ch = 8'($urandom_range(32, 255));
		if (ch == CH_SKIP) ch = CH_TILDE;
		noise = 1'b0;
		if (pick < 4) begin
			ch = 8'($urandom);
			return {REQ_CLEAR, ch};
		end
		if (pick < 16) return {REQ_PUT, CH_LF};
		if (pick < 24) begin
			noise = 1'b1;
			case ($urandom_range(0, 2))
				0: ch = CH_SKIP;
				1: ch = CH_CR;
				default: ch = 8'($urandom_range(CH_CTRL_LO, CH_CTRL_HI));
			endcase
			return {REQ_PUT, ch};
		end
		if (pick < 30) begin
			ch = 8'($urandom_range(0, 15));
			if (ch == CH_LF || ch == CH_CR) ch = 8'h00;
		end
		return {REQ_PUT, ch};
	endfunction

	task automatic queue_text(int count, bit plain_only);
		int made;
		bit noise;
		in_word_t w;
		made = 0;
		while (made < count) begin
			w = random_text_word(plain_only, noise);
			queue_word(w, $urandom_range(0, 39) == 0);
			if (!noise) made++;
		end
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_layout(logic four, logic [4:0] cols);
		apb_write({REG_FOUR_ROWS, 2'b00}, {31'd0, four});
		lay_four_rows = four;
		apb_write({REG_COLUMNS, 2'b00}, {27'd0, cols});
		lay_columns = cols;
		layout_count++;
	endtask

	task automatic drain_and_settle();
		while (words_taken != words_queued || display_ops_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		feed_t next_feed;
		logic next_valid;
		in_word_t next_word;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap = 0;
		end else begin
			next_valid = in_valid;
			next_word = in_data;
			if (in_valid && !in_stall) begin
				predict_display_ops(in_data);
				words_taken++;
				next_valid = 1'b0;
				if (idling && $urandom_range(0, 2) == 0) send_gap = $urandom_range(1, 4);
			end
			if (!next_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (text_feed_q.size() > 0 &&
						!(text_feed_q[0].drain && display_ops_q.size() != 0)) begin
					next_feed = text_feed_q.pop_front();
					next_valid = 1'b1;
					next_word = next_feed.word;
				end
			end
			in_valid <= next_valid;
			in_data <= next_word;
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				ops_checked++;
				if (display_ops_q.size() == 0) begin
					report_failure($sformatf("unexpected op: kind %0d addr %0d char %02h last %0b",
						out_data.op_kind, out_data.address, out_data.char_out, out_data.last));
				end else begin
					want = display_ops_q.pop_front();
					if (out_data.op_kind !== want.op_kind || out_data.address !== want.address ||
							out_data.char_out !== want.char_out || out_data.last !== want.last)
						report_failure($sformatf(
							"op %0d: expected kind %0d addr %0d char %02h last %0b, got %0d %0d %02h %0b",
							ops_checked, want.op_kind, want.address, want.char_out, want.last,
							out_data.op_kind, out_data.address, out_data.char_out, out_data.last));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d ops outstanding", CYCLE_LIMIT,
				display_ops_q.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [4:0] cols;
		for (int i = 0; i < SHADOW_SIZE; i++) shadow_text[i] = CH_SPACE;
		cursor_addr = '0;
		lay_four_rows = 1'b0;
		lay_columns = 5'd16;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// two rows of 16: byte extremes, remap, ignored codes, newline, two-row scroll, clear
		set_layout(1'b0, 5'd16);
		queue_word({REQ_PUT, 8'h00}, 1'b0);
		queue_word({REQ_PUT, 8'hFF}, 1'b0);
		queue_word({REQ_PUT, CH_TILDE}, 1'b0);
		queue_word({REQ_PUT, CH_SKIP}, 1'b0);
		queue_word({REQ_PUT, CH_CR}, 1'b0);
		queue_word({REQ_PUT, CH_CTRL_LO}, 1'b0);
		queue_word({REQ_PUT, CH_CTRL_HI}, 1'b0);
		queue_word({REQ_PUT, 8'h0F}, 1'b0);
		queue_word({REQ_PUT, CH_SPACE}, 1'b0);
		queue_word({REQ_PUT, CH_LF}, 1'b0);
		queue_word({REQ_PUT, 8'h42}, 1'b0);
		queue_word({REQ_PUT, CH_LF}, 1'b0);
		queue_word({REQ_CLEAR, 8'hFF}, 1'b0);
		queue_word({REQ_CLEAR, 8'h00}, 1'b0);
		drain_and_settle();

		// zero columns acts as one: walk every row end in four-row mode, scroll twice
		set_layout(1'b1, 5'd0);
		queue_word({REQ_PUT, 8'h78}, 1'b0);
		queue_word({REQ_PUT, 8'h79}, 1'b0);
		queue_word({REQ_PUT, 8'h7A}, 1'b0);
		queue_word({REQ_PUT, 8'h77}, 1'b0);
		queue_word({REQ_PUT, CH_LF}, 1'b0);
		drain_and_settle();

		// 31 columns acts as 20: newline through all four rows, then park cursor at 100
		set_layout(1'b1, 5'd31);
		queue_word({REQ_CLEAR, 8'h5A}, 1'b0);
		repeat (4) queue_word({REQ_PUT, CH_LF}, 1'b0);
		queue_text(16, 1'b1);
		drain_and_settle();

		// two rows, but newline reaches 64+2C: four-row scroll, then text toward it
		set_layout(1'b0, 5'd19);
		queue_word({REQ_PUT, CH_LF}, 1'b0);
		queue_text(12, 1'b1);
		drain_and_settle();

		// cursor beyond every row: writes past the shadow, wrap at 127
		set_layout(1'b1, 5'd5);
		queue_text(19, 1'b1);
		queue_word({REQ_PUT, 8'h41}, 1'b1);
		queue_text(20, 1'b1);
		drain_and_settle();

		// newline from outside every row, then mixed text
		set_layout(1'b0, 5'd1);
		queue_word({REQ_PUT, CH_LF}, 1'b0);
		queue_text(8, 1'b0);
		drain_and_settle();

		repeat (3) begin
			cols = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
				: 5'($urandom_range(1, 20));
			set_layout(1'($urandom_range(0, 1)), cols);
			queue_text(8, 1'b0);
			drain_and_settle();
		end

		idling = 1'b0;
		set_layout(1'b1, 5'd20);
		queue_text(8, 1'b0);
		drain_and_settle();

		$display("Sent %0d words over %0d layouts; checked %0d display ops, %0d scrolls.",
			words_taken, layout_count, ops_checked, scroll_count);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d failures", fail_count);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
